[src/tcvt_pkg.sv]
`default_nettype none

package tcvt_pkg;

   // Table size and length range
   localparam int MAX_LINES   = 4096;
   localparam int LENGTH_BITS = 12;

   localparam int IDX_W  = $clog2(MAX_LINES);
   localparam int ROW_W  = $clog2(MAX_LINES + 1);
   localparam int LEN_W  = LENGTH_BITS;
   localparam int REQ_LEN_W = 12;
   localparam int CFG_W  = 8;

   localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
   localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_LINES);

   // Configuration register indexes
   typedef enum logic [0:0] {
      REG_SCREEN_ROWS = 1'b0,
      REG_SCREEN_COLS = 1'b1
   } reg_index_type;

   // Item commands
   typedef enum logic [0:0] {
      CMD_APPEND = 1'b0,
      CMD_KEY    = 1'b1
   } command_type;

   // Key codes
   typedef enum logic [3:0] {
      KEY_LEFT      = 4'd0,
      KEY_RIGHT     = 4'd1,
      KEY_UP        = 4'd2,
      KEY_DOWN      = 4'd3,
      KEY_HOME      = 4'd4,
      KEY_END       = 4'd5,
      KEY_PAGE_UP   = 4'd6,
      KEY_PAGE_DOWN = 4'd7
   } key_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_STEP   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_SCROLL = 4'b1000
   } state_type;

   // Saturate an appended length to the table width
   function automatic logic [LEN_W-1:0] sat_len(input logic [REQ_LEN_W-1:0] len_in);
      logic [31:0] wide;
      wide = 32'(len_in);
      if (wide > 32'(LEN_MAX)) begin
         return LEN_MAX;
      end
      return wide[LEN_W-1:0];
   endfunction

   // A screen size of zero acts as one
   function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
      return (v == '0) ? CFG_W'(1) : v;
   endfunction

endpackage

`default_nettype wire

[src/text_cursor_viewport_tracker.sv]
`default_nettype none

// Text cursor and viewport tracker. Line lengths live in a 4096 x 12 single-port
// memory with a registered read; append items write the next entry (dropped when
// the table is full), key items move the cursor by reading line lengths, one read
// per cycle. An append, home, end or unknown key goes from idle straight to the
// scroll state; left, right, up and down pass through the step and drain states
// first; page up and page down stay in the step state for one memory read per
// visible row stepped. One item is worked on at a time; the result register
// lets the next item be taken while a result still waits, and a finished item
// holds in the scroll state only while that register is full and stalled. No
// clearing pass is needed: rows at or past lines_stored read as zero.
module text_cursor_viewport_tracker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write,
   input  wire logic [0:0]                  csr_index,
   input  wire logic [tcvt_pkg::CFG_W-1:0]  csr_wdata,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_command,
   input  wire logic [3:0]                  req_key_code,
   input  wire logic [tcvt_pkg::REQ_LEN_W-1:0] req_line_length,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [tcvt_pkg::LEN_W-1:0]       rsp_cursor_col,
   output logic [tcvt_pkg::ROW_W-1:0]       rsp_cursor_row,
   output logic [tcvt_pkg::ROW_W-1:0]       rsp_first_visible_row,
   output logic [tcvt_pkg::LEN_W-1:0]       rsp_first_visible_col,
   output logic [tcvt_pkg::ROW_W-1:0]       rsp_lines_stored
);
   import tcvt_pkg::*;

   state_type           state_ff, state_in;
   logic [ROW_W-1:0]    count_ff, count_in;
   logic [LEN_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ROW_W-1:0]    top_ff, top_in;
   logic [LEN_W-1:0]    left_ff, left_in;
   logic [CFG_W-1:0]    rows_cfg_ff, cols_cfg_ff;
   key_type             op_ff, op_in;
   logic [CFG_W-1:0]    steps_ff, steps_in;
   logic                wrap_ff, wrap_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [ROW_W-1:0]    rd_row_ff;
   logic [LEN_W-1:0]    rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]    rsp_col_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [ROW_W-1:0]    rsp_top_ff;
   logic [LEN_W-1:0]    rsp_left_ff;
   logic [ROW_W-1:0]    rsp_count_ff;

   logic [LEN_W-1:0]    mem [MAX_LINES];

   logic                mem_we;
   logic                mem_re;
   logic [ROW_W-1:0]    rd_addr;
   logic [LEN_W-1:0]    len_eff;
   logic [LEN_W-1:0]    col_cur;
   logic [LEN_W-1:0]    col_min;
   logic [CFG_W-1:0]    rows_eff, cols_eff;
   logic [ROW_W:0]      top_limit;
   logic [LEN_W:0]      left_limit;
   logic [ROW_W-1:0]    top_new;
   logic [LEN_W-1:0]    left_new;
   logic                on_line;
   logic                accept;
   logic                out_free;

   assign rows_eff  = eff_size(rows_cfg_ff);
   assign cols_eff  = eff_size(cols_cfg_ff);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Length of the row read last cycle; rows past the table read as zero
   assign len_eff = (rd_row_ff < count_ff) ? rd_data_ff : '0;
   assign col_cur = (rd_pend_ff && col_ff > len_eff) ? len_eff : col_ff;
   assign col_min = (col_ff > len_eff) ? len_eff : col_ff;
   assign on_line = row_ff < count_ff;

   // Scroll window that keeps the cursor on screen
   assign top_limit  = {1'b0, top_ff} + (ROW_W+1)'(rows_eff);
   assign left_limit = {1'b0, left_ff} + (LEN_W+1)'(cols_eff);

   always_comb begin
      top_new  = top_ff;
      left_new = left_ff;
      if (row_ff < top_ff) begin
         top_new = row_ff;
      end else if ({1'b0, row_ff} >= top_limit) begin
         top_new = ROW_W'(row_ff - ROW_W'(rows_eff) + ROW_W'(1));
      end
      if (col_ff < left_ff) begin
         left_new = col_ff;
      end else if ({1'b0, col_ff} >= left_limit) begin
         left_new = LEN_W'(col_ff - LEN_W'(cols_eff) + LEN_W'(1));
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      top_in       = top_ff;
      left_in      = left_ff;
      op_in        = op_ff;
      steps_in     = steps_ff;
      wrap_in      = wrap_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      rd_addr      = row_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_APPEND) begin
                  // store the length unless the table is full
                  if (count_ff < ROW_LIMIT) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + ROW_W'(1);
                  end
                  state_in = ST_SCROLL;
               end else begin
                  unique case (req_key_code)
                     KEY_HOME: begin
                        col_in   = '0;
                        state_in = ST_SCROLL;
                     end
                     KEY_END: begin
                        col_in   = LEN_W'(cols_eff - CFG_W'(1));
                        state_in = ST_SCROLL;
                     end
                     KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN: begin
                        op_in    = key_type'(req_key_code);
                        steps_in = CFG_W'(1);
                        state_in = ST_STEP;
                     end
                     KEY_PAGE_UP, KEY_PAGE_DOWN: begin
                        op_in    = key_type'(req_key_code);
                        steps_in = rows_eff;
                        state_in = ST_STEP;
                     end
                     default: begin
                        state_in = ST_SCROLL;
                     end
                  endcase
               end
            end
         end

         ST_STEP: begin
            // issue one row read per cycle, clamp with the previous read
            mem_re     = 1'b1;
            rd_pend_in = 1'b1;
            col_in     = col_cur;
            wrap_in    = 1'b0;
            unique case (op_ff)
               KEY_LEFT: begin
                  if (col_cur != '0) begin
                     col_in = col_cur - LEN_W'(1);
                  end else if (row_ff != '0) begin
                     rd_addr = row_ff - ROW_W'(1);
                     row_in  = row_ff - ROW_W'(1);
                     wrap_in = 1'b1;
                  end
               end
               KEY_UP, KEY_PAGE_UP: begin
                  if (row_ff != '0) begin
                     rd_addr = row_ff - ROW_W'(1);
                     row_in  = row_ff - ROW_W'(1);
                  end
               end
               KEY_DOWN, KEY_PAGE_DOWN: begin
                  if (row_ff < count_ff) begin
                     rd_addr = row_ff + ROW_W'(1);
                     row_in  = row_ff + ROW_W'(1);
                  end
               end
               default: begin
                  rd_addr = row_ff;
               end
            endcase
            steps_in = steps_ff - CFG_W'(1);
            if (steps_ff == CFG_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end

         ST_DRAIN: begin
            // finish the move with the last row length
            unique case (op_ff)
               KEY_LEFT: begin
                  col_in = wrap_ff ? len_eff : col_min;
               end
               KEY_RIGHT: begin
                  if (on_line && col_ff < len_eff) begin
                     col_in = col_ff + LEN_W'(1);
                  end else if (on_line && col_ff == len_eff) begin
                     row_in = row_ff + ROW_W'(1);
                     col_in = '0;
                  end else begin
                     col_in = col_min;
                  end
               end
               default: begin
                  col_in = col_min;
               end
            endcase
            state_in = ST_SCROLL;
         end

         ST_SCROLL: begin
            // adjust the window and load the result once the output is free
            if (out_free) begin
               top_in       = top_new;
               left_in      = left_new;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         left_ff      <= '0;
         op_ff        <= KEY_LEFT;
         steps_ff     <= '0;
         wrap_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         left_ff      <= left_in;
         op_ff        <= op_in;
         steps_ff     <= steps_in;
         wrap_ff      <= wrap_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Screen size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= CFG_W'(24);
         cols_cfg_ff <= CFG_W'(80);
      end else if (csr_write) begin
         if (csr_index == REG_SCREEN_ROWS) begin
            rows_cfg_ff <= csr_wdata;
         end else begin
            cols_cfg_ff <= csr_wdata;
         end
      end
   end

   // Line length memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= sat_len(req_line_length);
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr[IDX_W-1:0]];
         rd_row_ff  <= rd_addr;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCROLL && out_free) begin
         rsp_col_ff   <= col_ff;
         rsp_row_ff   <= row_ff;
         rsp_top_ff   <= top_new;
         rsp_left_ff  <= left_new;
         rsp_count_ff <= count_ff;
      end
   end

   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_cursor_col        = rsp_col_ff;
   assign rsp_cursor_row        = rsp_row_ff;
   assign rsp_first_visible_row = rsp_top_ff;
   assign rsp_first_visible_col = rsp_left_ff;
   assign rsp_lines_stored      = rsp_count_ff;

endmodule

`default_nettype wire

[src/tcvt_checker.sv]
`default_nettype none

module tcvt_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_stall,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic [tcvt_pkg::LEN_W-1:0]  rsp_cursor_col,
   input  wire logic [tcvt_pkg::ROW_W-1:0]  rsp_cursor_row,
   input  wire logic [tcvt_pkg::ROW_W-1:0]  rsp_first_visible_row,
   input  wire logic [tcvt_pkg::LEN_W-1:0]  rsp_first_visible_col,
   input  wire logic [tcvt_pkg::ROW_W-1:0]  rsp_lines_stored
);

   // An accepted item keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after an item");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_row)
         && $stable(rsp_cursor_col) && $stable(rsp_lines_stored))
      else $error("stalled result changed");

   // Cursor row never passes the line count
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_row <= rsp_lines_stored)
      else $error("cursor row beyond line count");

   // Cursor stays right of and below the window origin
   a_row_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_first_visible_row <= rsp_cursor_row)
      else $error("cursor row above the window");

   a_col_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_first_visible_col <= rsp_cursor_col)
      else $error("cursor column left of the window");

endmodule

bind text_cursor_viewport_tracker tcvt_checker u_tcvt_checker (.*);

`default_nettype wire
